[hdl/tals_pkg.sv]
`default_nettype none
package tals_pkg;

  localparam int MIN_STEPS = 3;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] ONE_Q30 = 64'sh0000_0000_4000_0000;

  // product scaling: level factors, weights/discount, payoff gearing
  typedef enum logic [1:0] {
    SH_LVL,
    SH_WGT,
    SH_PAY
  } shift_t;

  typedef enum logic [1:0] {
    ACT_PRICE,
    ACT_DELTA,
    ACT_ZERO,
    ACT_SPARE
  } action_t;

  typedef enum logic [2:0] {
    REG_UP_FIRST,
    REG_DOWN_FIRST,
    REG_UP_SECOND,
    REG_DOWN_SECOND,
    REG_PROB_UU,
    REG_PROB_UD,
    REG_PROB_DU,
    REG_STEPS
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LV_START,
    ST_LV_STEP,
    ST_LV_WAIT,
    ST_GF_RD,
    ST_GF_M1,
    ST_GF_W1,
    ST_GF_W2,
    ST_RB_RD,
    ST_RB_MUL,
    ST_RB_WAIT,
    ST_RB_WR,
    ST_FN_RD,
    ST_FN_MUL,
    ST_FN_WAIT,
    ST_PR_MUL,
    ST_PR_WAIT,
    ST_NM_MUL,
    ST_NM_WAIT,
    ST_DN_MUL,
    ST_DN_WAIT,
    ST_DV_RUN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    shift_t            sh;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic signed [63:0] res;
    logic [127:0]      prod;
  } mul_rsp_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    mag64 = x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic signed [63:0] from_mag(input logic [63:0] m, input logic neg,
                                                  input logic over);
    if (neg) begin
      from_mag = (over || m[63]) ? S64_MIN : -$signed(m);
    end else begin
      from_mag = (over || m[63]) ? S64_MAX : $signed(m);
    end
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sadd = s[64] ? S64_MIN : S64_MAX;
    else sadd = s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) ssub = s[64] ? S64_MIN : S64_MAX;
    else ssub = s[63:0];
  endfunction

endpackage
`default_nettype wire

[hdl/two_asset_lattice_spread_pricer.sv]
`default_nettype none
// speed: set by the one shared multiplier and one grid read port; the premium adds a weighted
//   sum of four products, delta (unless flat) adds three products and the divide; zero skips the lattice
// throughput: one word at a time; the next word is taken once the result is registered
// reset: rst_n synchronous active low; registers return to unit factors, 0.25 weights,
//   3 steps; the level and grid memories keep no reset and are written before reading
module two_asset_lattice_spread_pricer #(
  parameter int MAX_STEPS = 63
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  // fwd_first, fwd_second, strike, gear_first, gear_second, discount
  input  wire logic [351:0] in_tdata,
  // call_or_put, action
  input  wire logic [2:0]   in_tuser,
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  // value
  output      logic [63:0]  out_tdata,
  input  wire logic         cfg_wr_en,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import tals_pkg::*;

  localparam int LW = $clog2(MAX_STEPS + 1);
  localparam int GW = 2 * LW;

  // configuration
  logic [31:0] up1_r, dn1_r, up2_r, dn2_r;
  logic signed [31:0] puu_r, pud_r, pdu_r;
  logic [5:0]  steps_r;

  // request
  logic signed [63:0] f1_r, f2_r, k_r, ga_r, gb_r, disc_r;
  logic        put_r;
  action_t     act_r;
  logic signed [63:0] w_r [4];
  logic [LW-1:0] n_r;

  state_t state_r, state_nxt;
  logic        sel_r;
  logic [LW-1:0] i_r, j_r, kc_r, wdt_r;
  logic [1:0]  q_r;
  logic signed [63:0] x_r, t1_r, acc_r;
  logic signed [63:0] d_r [4];

  // divider
  logic [127:0] dv_n_r, dv_rem_r, dv_d_r;
  logic [63:0]  dv_q_r;
  logic         dv_ov_r, dv_neg_r;
  logic [6:0]   dv_cnt_r;

  logic         out_tvalid_r;
  logic [63:0]  out_tdata_r;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  logic          lv1_we, lv2_we;
  logic [63:0]   lv1_q, lv2_q;
  logic          gr_we;
  logic [GW-1:0] gr_waddr, gr_raddr;
  logic [63:0]   gr_wdata, gr_q;

  logic [LW-1:0] n_clamp;
  logic          lv_done, use_up, lv_last, flat;
  logic          cell_last, rb_last;
  logic signed [63:0] pay_a, pay_b, pay_c, pay_val, acc_nxt;
  logic signed [32:0] dif;
  logic [127:0] rem_sh, rem_nxt;
  logic         ge;
  logic [63:0]  q_nxt;
  logic         ov_nxt;

  tals_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  tals_ram #(.WIDTH(64), .DEPTH(MAX_STEPS + 1)) u_lv1 (
    .clk(clk), .we(lv1_we), .waddr(i_r), .wdata(x_r), .raddr(i_r), .rdata(lv1_q)
  );
  tals_ram #(.WIDTH(64), .DEPTH(MAX_STEPS + 1)) u_lv2 (
    .clk(clk), .we(lv2_we), .waddr(i_r), .wdata(x_r), .raddr(j_r), .rdata(lv2_q)
  );
  tals_ram #(.WIDTH(64), .DEPTH(1 << GW)) u_grid (
    .clk(clk), .we(gr_we), .waddr(gr_waddr), .wdata(gr_wdata), .raddr(gr_raddr),
    .rdata(gr_q)
  );

  // step count clamp
  always_comb begin
    if (int'(steps_r) < MIN_STEPS) n_clamp = LW'(MIN_STEPS);
    else if (int'(steps_r) > MAX_STEPS) n_clamp = LW'(MAX_STEPS);
    else n_clamp = LW'(steps_r);
  end

  assign lv_done   = (kc_r == n_r);
  assign use_up    = ({1'b0, kc_r} + {1'b0, i_r}) < {1'b0, n_r};
  assign lv_last   = (i_r == n_r);
  assign cell_last = (i_r == n_r) && (j_r == n_r);
  assign rb_last   = (wdt_r == LW'(1)) && (i_r == wdt_r) && (j_r == wdt_r);
  assign flat      = (up1_r == dn1_r) || (f1_r == 64'sd0);
  assign dif       = $signed({1'b0, up1_r}) - $signed({1'b0, dn1_r});

  // payoff of one leaf
  always_comb begin
    pay_a = ssub(t1_r, mrsp.res);
    pay_b = ssub(pay_a, k_r);
    if (put_r) pay_c = (pay_b == S64_MIN) ? S64_MAX : -pay_b;
    else pay_c = pay_b;
    pay_val = (pay_c > 64'sd0) ? pay_c : 64'sd0;
  end

  assign acc_nxt = (q_r == 2'd0) ? mrsp.res : sadd(acc_r, mrsp.res);

  // restoring divide, one quotient bit per cycle
  assign rem_sh  = {dv_rem_r[126:0], dv_n_r[127]};
  assign ge      = rem_sh >= dv_d_r;
  assign rem_nxt = ge ? (rem_sh - dv_d_r) : rem_sh;
  assign q_nxt   = {dv_q_r[62:0], ge};
  assign ov_nxt  = dv_ov_r | dv_q_r[63];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser[2:1] == ACT_PRICE || in_tuser[2:1] == ACT_DELTA) begin
            state_nxt = ST_LV_START;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_LV_START: state_nxt = ST_LV_STEP;
      ST_LV_STEP: begin
        if (!lv_done) state_nxt = ST_LV_WAIT;
        else if (lv_last && sel_r) state_nxt = ST_GF_RD;
        else state_nxt = ST_LV_START;
      end
      ST_LV_WAIT: if (mrsp.done) state_nxt = ST_LV_STEP;
      ST_GF_RD:   state_nxt = ST_GF_M1;
      ST_GF_M1:   state_nxt = ST_GF_W1;
      ST_GF_W1:   if (mrsp.done) state_nxt = ST_GF_W2;
      ST_GF_W2: begin
        if (mrsp.done) state_nxt = cell_last ? ST_RB_RD : ST_GF_RD;
      end
      ST_RB_RD:   state_nxt = ST_RB_MUL;
      ST_RB_MUL:  state_nxt = ST_RB_WAIT;
      ST_RB_WAIT: if (mrsp.done) state_nxt = (q_r == 2'd3) ? ST_RB_WR : ST_RB_RD;
      ST_RB_WR:   state_nxt = rb_last ? ST_FN_RD : ST_RB_RD;
      ST_FN_RD:   state_nxt = ST_FN_MUL;
      ST_FN_MUL:  state_nxt = ST_FN_WAIT;
      ST_FN_WAIT: begin
        if (mrsp.done) begin
          if (q_r != 2'd3) state_nxt = ST_FN_RD;
          else if (act_r == ACT_PRICE) state_nxt = ST_PR_MUL;
          else if (flat) state_nxt = ST_OUT;
          else state_nxt = ST_NM_MUL;
        end
      end
      ST_PR_MUL:  state_nxt = ST_PR_WAIT;
      ST_PR_WAIT: if (mrsp.done) state_nxt = (q_r == 2'd3) ? ST_OUT : ST_PR_MUL;
      ST_NM_MUL:  state_nxt = ST_NM_WAIT;
      ST_NM_WAIT: if (mrsp.done) state_nxt = (q_r == 2'd1) ? ST_DN_MUL : ST_NM_MUL;
      ST_DN_MUL:  state_nxt = ST_DN_WAIT;
      ST_DN_WAIT: if (mrsp.done) state_nxt = ST_DV_RUN;
      ST_DV_RUN:  if (dv_cnt_r == 7'd127) state_nxt = ST_OUT;
      ST_OUT:     if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // memory and multiplier controls
  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = x_r;
    mreq.b     = 64'sd0;
    mreq.sh    = SH_WGT;
    lv1_we     = 1'b0;
    lv2_we     = 1'b0;
    gr_we      = 1'b0;
    gr_waddr   = {i_r, j_r};
    gr_wdata   = acc_r;
    gr_raddr   = {i_r + LW'(q_r[1]), j_r + LW'(q_r[0])};
    unique case (state_r)
      ST_LV_STEP: begin
        if (lv_done) begin
          lv1_we = !sel_r;
          lv2_we = sel_r;
        end else begin
          mreq.start = 1'b1;
          mreq.a     = x_r;
          if (sel_r) mreq.b = {32'd0, use_up ? up2_r : dn2_r};
          else mreq.b = {32'd0, use_up ? up1_r : dn1_r};
          mreq.sh = SH_LVL;
        end
      end
      ST_GF_M1: begin
        mreq.start = 1'b1;
        mreq.a     = ga_r;
        mreq.b     = lv1_q;
        mreq.sh    = SH_PAY;
      end
      ST_GF_W1: begin
        mreq.start = mrsp.done;
        mreq.a     = gb_r;
        mreq.b     = lv2_q;
        mreq.sh    = SH_PAY;
      end
      ST_GF_W2: begin
        gr_we    = mrsp.done;
        gr_wdata = pay_val;
      end
      ST_RB_MUL, ST_PR_MUL: begin
        mreq.start = 1'b1;
        mreq.a     = w_r[q_r];
        mreq.b     = (state_r == ST_RB_MUL) ? gr_q : d_r[q_r];
      end
      ST_RB_WR: gr_we = 1'b1;
      ST_FN_MUL: begin
        mreq.start = 1'b1;
        mreq.a     = disc_r;
        mreq.b     = gr_q;
      end
      ST_NM_MUL: begin
        mreq.start = 1'b1;
        if (q_r == 2'd0) begin
          mreq.a = w_r[0] + w_r[2];
          mreq.b = ssub(d_r[0], d_r[2]);
        end else begin
          mreq.a = w_r[1] + w_r[3];
          mreq.b = ssub(d_r[1], d_r[3]);
        end
      end
      ST_DN_MUL: begin
        mreq.start = 1'b1;
        mreq.a     = {{31{dif[32]}}, dif};
        mreq.b     = f1_r;
      end
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up1_r   <= 32'h1000_0000;
      dn1_r   <= 32'h1000_0000;
      up2_r   <= 32'h1000_0000;
      dn2_r   <= 32'h1000_0000;
      puu_r   <= 32'sh1000_0000;
      pud_r   <= 32'sh1000_0000;
      pdu_r   <= 32'sh1000_0000;
      steps_r <= 6'd3;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_UP_FIRST:    up1_r   <= cfg_data;
        REG_DOWN_FIRST:  dn1_r   <= cfg_data;
        REG_UP_SECOND:   up2_r   <= cfg_data;
        REG_DOWN_SECOND: dn2_r   <= cfg_data;
        REG_PROB_UU:     puu_r   <= cfg_data;
        REG_PROB_UD:     pud_r   <= cfg_data;
        REG_PROB_DU:     pdu_r   <= cfg_data;
        REG_STEPS:       steps_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && (!out_tvalid_r || out_tready)) out_tvalid_r <= 1'b1;
      else if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        f1_r   <= in_tdata[63:0];
        f2_r   <= in_tdata[127:64];
        k_r    <= in_tdata[191:128];
        ga_r   <= in_tdata[255:192];
        gb_r   <= in_tdata[319:256];
        disc_r <= {32'd0, in_tdata[351:320]};
        put_r  <= in_tuser[0];
        act_r  <= action_t'(in_tuser[2:1]);
        w_r[0] <= 64'(puu_r);
        w_r[1] <= 64'(pud_r);
        w_r[2] <= 64'(pdu_r);
        w_r[3] <= ONE_Q30 - 64'(puu_r) - 64'(pud_r) - 64'(pdu_r);
        n_r    <= n_clamp;
        sel_r  <= 1'b0;
        i_r    <= '0;
        acc_r  <= 64'sd0;
      end
      ST_LV_START: begin
        x_r  <= sel_r ? f2_r : f1_r;
        kc_r <= '0;
      end
      ST_LV_STEP: begin
        if (lv_done) begin
          if (lv_last) begin
            i_r   <= '0;
            j_r   <= '0;
            sel_r <= 1'b1;
          end else begin
            i_r <= i_r + LW'(1);
          end
        end
      end
      ST_LV_WAIT: begin
        if (mrsp.done) begin
          x_r  <= mrsp.res;
          kc_r <= kc_r + LW'(1);
        end
      end
      ST_GF_W1: if (mrsp.done) t1_r <= mrsp.res;
      ST_GF_W2: begin
        if (mrsp.done) begin
          q_r   <= 2'd0;
          wdt_r <= n_r - LW'(1);
          if (j_r == n_r) begin
            j_r <= '0;
            i_r <= (i_r == n_r) ? '0 : i_r + LW'(1);
          end else begin
            j_r <= j_r + LW'(1);
          end
        end
      end
      ST_RB_WAIT, ST_PR_WAIT, ST_NM_WAIT: begin
        if (mrsp.done) begin
          acc_r <= acc_nxt;
          q_r   <= q_r + 2'd1;
        end
      end
      ST_RB_WR: begin
        q_r <= 2'd0;
        if (j_r == wdt_r) begin
          j_r <= '0;
          if (i_r == wdt_r) begin
            i_r <= '0;
            if (!rb_last) wdt_r <= wdt_r - LW'(1);
          end else begin
            i_r <= i_r + LW'(1);
          end
        end else begin
          j_r <= j_r + LW'(1);
        end
      end
      ST_FN_WAIT: begin
        if (mrsp.done) begin
          d_r[q_r] <= mrsp.res;
          q_r      <= q_r + 2'd1;
          acc_r    <= 64'sd0;
        end
      end
      ST_DN_WAIT: begin
        if (mrsp.done) begin
          dv_d_r   <= mrsp.prod;
          dv_n_r   <= {4'd0, mag64(acc_r), 60'd0};
          dv_rem_r <= '0;
          dv_q_r   <= '0;
          dv_ov_r  <= 1'b0;
          dv_cnt_r <= '0;
          dv_neg_r <= acc_r[63] ^ dif[32] ^ f1_r[63];
        end
      end
      ST_DV_RUN: begin
        dv_rem_r <= rem_nxt;
        dv_n_r   <= {dv_n_r[126:0], 1'b0};
        dv_q_r   <= q_nxt;
        dv_ov_r  <= ov_nxt;
        dv_cnt_r <= dv_cnt_r + 7'd1;
        if (dv_cnt_r == 7'd127) begin
          acc_r <= from_mag(ov_nxt ? '1 : q_nxt, dv_neg_r, 1'b0);
        end
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) out_tdata_r <= acc_r;
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire

[hdl/tals_ram.sv]
`default_nettype none
module tals_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/tals_mul.sv]
`default_nettype none
module tals_mul (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tals_pkg::mul_req_t req,
  output      tals_pkg::mul_rsp_t rsp
);
  import tals_pkg::*;

  logic          busy_r;
  logic          fin_r;
  logic [1:0]    cnt_r;
  logic          neg_r;
  shift_t        sh_r;
  logic [63:0]   ma_r;
  logic [63:0]   mb_r;
  logic [127:0]  acc_r;
  logic          done_r;
  logic signed [63:0] res_r;
  logic [127:0]  prod_r;

  logic [31:0]   a_half;
  logic [31:0]   b_half;
  logic [63:0]   pp;
  logic [127:0]  pp_sh;
  logic [127:0]  rnd;
  logic          over;
  logic [63:0]   m;

  // one 32x32 partial product per cycle
  assign a_half = cnt_r[1] ? ma_r[63:32] : ma_r[31:0];
  assign b_half = cnt_r[0] ? mb_r[63:32] : mb_r[31:0];
  assign pp     = a_half * b_half;

  always_comb begin
    case (cnt_r)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // round half away from zero on the magnitude, then saturate
  always_comb begin
    case (sh_r)
      SH_LVL: begin
        rnd  = acc_r + (128'd1 << 27);
        over = |rnd[127:92];
        m    = rnd[91:28];
      end
      SH_WGT: begin
        rnd  = acc_r + (128'd1 << 29);
        over = |rnd[127:94];
        m    = rnd[93:30];
      end
      default: begin
        rnd  = acc_r + (128'd1 << 31);
        over = |rnd[127:96];
        m    = rnd[95:32];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= busy_r && fin_r;
      if (!busy_r) begin
        if (req.start) begin
          busy_r <= 1'b1;
          fin_r  <= 1'b0;
          cnt_r  <= 2'd0;
          ma_r   <= mag64(req.a);
          mb_r   <= mag64(req.b);
          neg_r  <= req.a[63] ^ req.b[63];
          sh_r   <= req.sh;
          acc_r  <= '0;
        end
      end else if (!fin_r) begin
        acc_r <= acc_r + pp_sh;
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) fin_r <= 1'b1;
      end else begin
        busy_r <= 1'b0;
        res_r  <= from_mag(m, neg_r, over);
        prod_r <= acc_r;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;
  assign rsp.prod = prod_r;

endmodule
`default_nettype wire

[hdl/tals_checker.sv]
`default_nettype none
module tals_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped or changed while stalled");

  // one request in flight: busy right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while busy");

  // an idle block with an empty output does not invent a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result without a request");

  // nothing pending just after reset
  a_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("not idle after reset");

endmodule

bind two_asset_lattice_spread_pricer tals_checker u_tals_checker (.*);
`default_nettype wire
